// ===== rtl/core/nvmeqp_pkg.sv =====
// Shared types and constants for the NVMe queue pair engine.
// No dependencies; used by nvmeqp_beat_gen and nvme_queue_pair_engine.
package nvmeqp_pkg;

   localparam int QUEUE_DEPTH_DEFAULT = 64;
   localparam int SQE_DWORDS          = 16;
   localparam int BEAT_W              = 5;
   localparam int CSR_INDEX_W         = 3;
   localparam logic [63:0] DB_OFFSET  = 64'h1000;
   localparam logic [3:0]  CQE_DW3_OFS = 4'hC;

   // submission entry dword slots
   localparam logic [3:0] DW_CDW0  = 4'd0;
   localparam logic [3:0] DW_NSID  = 4'd1;
   localparam logic [3:0] DW_PRP_L = 4'd6;
   localparam logic [3:0] DW_PRP_H = 4'd7;
   localparam logic [3:0] DW_CDW10 = 4'd10;
   localparam logic [3:0] DW_CDW11 = 4'd11;
   localparam logic [3:0] DW_CDW12 = 4'd12;

   localparam logic OP_SUBMIT     = 1'b0;
   localparam logic OP_COMPLETION = 1'b1;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_CTRL_BASE  = 3'd0,
      CSR_DB_STRIDE  = 3'd1,
      CSR_QUEUE_ID   = 3'd2,
      CSR_SQ_BASE    = 3'd3,
      CSR_CQ_BASE    = 3'd4
   } csr_index_type;

   typedef enum logic [1:0] {
      KIND_ENTRY    = 2'd0,
      KIND_DOORBELL = 2'd1,
      KIND_DONE     = 2'd2,
      KIND_EMPTY    = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      JOB_SUBMIT   = 2'd0,
      JOB_CPL_ONLY = 2'd1,
      JOB_CPL_DONE = 2'd2,
      JOB_CPL_NONE = 2'd3
   } job_type;

   typedef struct packed {
      logic [63:0] controller_base;
      logic [3:0]  stride_log;
      logic [15:0] queue_id;
      logic [63:0] sq_base;
      logic [63:0] cq_base;
   } cfg_type;

   typedef struct packed {
      job_type     job;
      logic [15:0] cid;
      logic [7:0]  opcode;
      logic [31:0] nsid;
      logic [63:0] prp1;
      logic [31:0] dw10;
      logic [31:0] dw11;
      logic [31:0] dw12;
      logic [10:0] status;
   } work_type;

   typedef struct packed {
      kind_type    kind;
      logic [63:0] address;
      logic [31:0] write_data;
      logic [15:0] command_id;
      logic [10:0] status_code;
      logic        last;
   } rsp_beat_type;

endpackage

// ===== rtl/core/nvmeqp_beat_gen.sv =====
// Result beat builder: forms one output beat from the held item and beat index.
// Depends on nvmeqp_pkg.
module nvmeqp_beat_gen #(
   parameter int PTR_W = 6
) (
   input  nvmeqp_pkg::work_type               work,
   input  logic [PTR_W-1:0]                   ptr,
   input  logic [PTR_W-1:0]                   new_ptr,
   input  logic [nvmeqp_pkg::BEAT_W-1:0]      beat,
   input  nvmeqp_pkg::cfg_type                cfg,
   output nvmeqp_pkg::rsp_beat_type           rsp
);

   logic [16:0] db_idx;
   logic [4:0]  db_shift;
   logic [63:0] db_off;
   logic [63:0] add_base;
   logic [63:0] add_off;
   logic [31:0] entry_dw;
   logic        is_cq_db;

   assign is_cq_db = (work.job != nvmeqp_pkg::JOB_SUBMIT);
   assign db_idx   = {cfg.queue_id, is_cq_db};
   assign db_shift = 5'(cfg.stride_log) + 5'd2;
   assign db_off   = nvmeqp_pkg::DB_OFFSET + (64'(db_idx) << db_shift);

   always_comb begin
      case (beat[3:0])
         nvmeqp_pkg::DW_CDW0:  entry_dw = {work.cid, 8'h00, work.opcode};
         nvmeqp_pkg::DW_NSID:  entry_dw = work.nsid;
         nvmeqp_pkg::DW_PRP_L: entry_dw = work.prp1[31:0];
         nvmeqp_pkg::DW_PRP_H: entry_dw = work.prp1[63:32];
         nvmeqp_pkg::DW_CDW10: entry_dw = work.dw10;
         nvmeqp_pkg::DW_CDW11: entry_dw = work.dw11;
         nvmeqp_pkg::DW_CDW12: entry_dw = work.dw12;
         default:              entry_dw = '0;
      endcase
   end

   always_comb begin
      add_base        = '0;
      add_off         = '0;
      rsp.kind        = nvmeqp_pkg::KIND_DOORBELL;
      rsp.write_data  = 32'(new_ptr);
      rsp.command_id  = work.cid;
      rsp.status_code = '0;
      rsp.last        = 1'b1;
      case (work.job)
         nvmeqp_pkg::JOB_SUBMIT: begin
            if (beat == nvmeqp_pkg::BEAT_W'(nvmeqp_pkg::SQE_DWORDS)) begin
               add_base = cfg.controller_base;
               add_off  = db_off;
            end else begin
               rsp.kind       = nvmeqp_pkg::KIND_ENTRY;
               rsp.write_data = entry_dw;
               rsp.last       = 1'b0;
               add_base       = cfg.sq_base;
               add_off        = 64'({ptr, beat[3:0], 2'b00});
            end
         end
         nvmeqp_pkg::JOB_CPL_ONLY: begin
            add_base = cfg.controller_base;
            add_off  = db_off;
         end
         nvmeqp_pkg::JOB_CPL_DONE: begin
            if (beat == '0) begin
               rsp.last = 1'b0;
               add_base = cfg.controller_base;
               add_off  = db_off;
            end else begin
               rsp.kind        = nvmeqp_pkg::KIND_DONE;
               rsp.write_data  = '0;
               rsp.status_code = work.status;
            end
         end
         nvmeqp_pkg::JOB_CPL_NONE: begin
            rsp.kind       = nvmeqp_pkg::KIND_EMPTY;
            rsp.write_data = '0;
            rsp.command_id = '0;
            add_base       = cfg.cq_base;
            add_off        = 64'({ptr, nvmeqp_pkg::CQE_DW3_OFS});
         end
         default: begin
            rsp.kind = nvmeqp_pkg::KIND_EMPTY;
         end
      endcase
      rsp.address = add_base + add_off;
   end

endmodule

// ===== rtl/core/nvme_queue_pair_engine.sv =====
// NVMe queue pair engine top level: one item register, beat builder, result register.
// An accepted item loads the item register; its beats then load the result register.
// Throughput: one result beat per cycle while rsp_ready allows; a submit gives 17 beats, a completion 1 or 2.
// The next item is taken as the last beat loads.
// Reset (synchronous, active high): tail 0, head 0, phase 1, next id 1; config, pending id, valid flags, beat 0.
// Depends on nvmeqp_pkg and nvmeqp_beat_gen.
module nvme_queue_pair_engine #(
   parameter int QUEUE_DEPTH = nvmeqp_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_op,
   input  logic [7:0]  req_cmd_opcode,
   input  logic [31:0] req_namespace_id,
   input  logic [63:0] req_buffer_addr,
   input  logic [31:0] req_cmd_dword10,
   input  logic [31:0] req_cmd_dword11,
   input  logic [31:0] req_cmd_dword12,
   input  logic [31:0] req_completion_dword3,

   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_kind,
   output logic [63:0] rsp_address,
   output logic [31:0] rsp_write_data,
   output logic [15:0] rsp_command_id,
   output logic [10:0] rsp_status_code,
   output logic        rsp_last,

   input  logic                                csr_we,
   input  logic [nvmeqp_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [63:0]                         csr_wdata
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

   nvmeqp_pkg::cfg_type      cfg_ff;
   nvmeqp_pkg::work_type     work_ff, work_in;
   nvmeqp_pkg::rsp_beat_type rsp_ff, beat_rsp;

   logic                          work_valid_ff;
   logic [nvmeqp_pkg::BEAT_W-1:0] beat_ff;
   logic [PTR_W-1:0]              ptr_ff, ptr_in;
   logic [PTR_W-1:0]              new_ptr_ff, new_ptr_in;
   logic                          rsp_valid_ff;

   logic [PTR_W-1:0] sq_tail_ff, cq_head_ff;
   logic             phase_ff;
   logic [15:0]      next_cid_ff, pending_cid_ff;

   logic             req_fire, out_adv, beat_load, item_done;
   logic [PTR_W-1:0] sq_tail_inc, cq_head_inc;
   logic [15:0]      cpl_cid;

   assign out_adv   = !rsp_valid_ff || rsp_ready;
   assign beat_load = work_valid_ff && out_adv;
   assign item_done = beat_load && beat_rsp.last;
   assign req_ready = !work_valid_ff || item_done;
   assign req_fire  = req_valid && req_ready;

   assign sq_tail_inc = (sq_tail_ff == PTR_LAST) ? '0 : sq_tail_ff + 1'b1;
   assign cq_head_inc = (cq_head_ff == PTR_LAST) ? '0 : cq_head_ff + 1'b1;
   assign cpl_cid     = req_completion_dword3[15:0];

   always_comb begin
      work_in.cid    = next_cid_ff;
      work_in.opcode = req_cmd_opcode;
      work_in.nsid   = req_namespace_id;
      work_in.prp1   = req_buffer_addr;
      work_in.dw10   = req_cmd_dword10;
      work_in.dw11   = req_cmd_dword11;
      work_in.dw12   = req_cmd_dword12;
      work_in.status = req_completion_dword3[27:17];
      work_in.job    = nvmeqp_pkg::JOB_SUBMIT;
      ptr_in         = sq_tail_ff;
      new_ptr_in     = sq_tail_inc;
      if (req_op == nvmeqp_pkg::OP_COMPLETION) begin
         work_in.cid = cpl_cid;
         ptr_in      = cq_head_ff;
         new_ptr_in  = cq_head_inc;
         if (req_completion_dword3[16] != phase_ff) begin
            work_in.job = nvmeqp_pkg::JOB_CPL_NONE;
         end else if (cpl_cid == pending_cid_ff) begin
            work_in.job = nvmeqp_pkg::JOB_CPL_DONE;
         end else begin
            work_in.job = nvmeqp_pkg::JOB_CPL_ONLY;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            nvmeqp_pkg::CSR_CTRL_BASE: cfg_ff.controller_base <= csr_wdata;
            nvmeqp_pkg::CSR_DB_STRIDE: cfg_ff.stride_log      <= csr_wdata[3:0];
            nvmeqp_pkg::CSR_QUEUE_ID:  cfg_ff.queue_id        <= csr_wdata[15:0];
            nvmeqp_pkg::CSR_SQ_BASE:   cfg_ff.sq_base         <= csr_wdata;
            nvmeqp_pkg::CSR_CQ_BASE:   cfg_ff.cq_base         <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_tail_ff     <= '0;
         cq_head_ff     <= '0;
         phase_ff       <= 1'b1;
         next_cid_ff    <= 16'd1;
         pending_cid_ff <= '0;
      end else if (req_fire) begin
         if (req_op == nvmeqp_pkg::OP_SUBMIT) begin
            sq_tail_ff     <= sq_tail_inc;
            pending_cid_ff <= next_cid_ff;
            next_cid_ff    <= next_cid_ff + 16'd1;
         end else if (req_completion_dword3[16] == phase_ff) begin
            cq_head_ff <= cq_head_inc;
            if (cq_head_inc == '0) begin
               phase_ff <= !phase_ff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         work_valid_ff <= 1'b0;
         beat_ff       <= '0;
      end else if (req_fire) begin
         work_valid_ff <= 1'b1;
         beat_ff       <= '0;
      end else if (item_done) begin
         work_valid_ff <= 1'b0;
      end else if (beat_load) begin
         beat_ff <= beat_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         work_ff    <= work_in;
         ptr_ff     <= ptr_in;
         new_ptr_ff <= new_ptr_in;
      end
   end

   nvmeqp_beat_gen #(
      .PTR_W (PTR_W)
   ) u_beat_gen (
      .work    (work_ff),
      .ptr     (ptr_ff),
      .new_ptr (new_ptr_ff),
      .beat    (beat_ff),
      .cfg     (cfg_ff),
      .rsp     (beat_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_adv) begin
         rsp_valid_ff <= work_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (beat_load) begin
         rsp_ff <= beat_rsp;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_kind        = rsp_ff.kind;
   assign rsp_address     = rsp_ff.address;
   assign rsp_write_data  = rsp_ff.write_data;
   assign rsp_command_id  = rsp_ff.command_id;
   assign rsp_status_code = rsp_ff.status_code;
   assign rsp_last        = rsp_ff.last;

   a_ptr_range: assert property (@(posedge clock) disable iff (reset)
      (32'(sq_tail_ff) < QUEUE_DEPTH) && (32'(cq_head_ff) < QUEUE_DEPTH))
      else $error("queue pointer out of range");

   a_beat_range: assert property (@(posedge clock) disable iff (reset)
      work_valid_ff |-> (beat_ff <= nvmeqp_pkg::BEAT_W'(nvmeqp_pkg::SQE_DWORDS)))
      else $error("beat index past end of entry");

   a_pending_cid: assert property (@(posedge clock) disable iff (reset)
      (req_fire && (req_op == nvmeqp_pkg::OP_SUBMIT))
      |=> (pending_cid_ff == $past(next_cid_ff)) && (work_ff.cid == pending_cid_ff))
      else $error("pending command id not taken from submitted beat");

   a_last_frees: assert property (@(posedge clock) disable iff (reset)
      (item_done && !req_fire) |=> (!work_valid_ff && rsp_valid_ff && rsp_ff.last))
      else $error("item register not released after final beat");

endmodule

// ===== dv/tb_nvme_queue_pair_engine.sv =====
// Self-checking testbench for nvme_queue_pair_engine: a directed stimulus table, then random
// submit and completion traffic, with every result beat checked against an in-bench predictor.
// Depends on nvmeqp_pkg and the nvme_queue_pair_engine RTL.
`timescale 1ns / 1ps

module tb_nvme_queue_pair_engine;

   localparam int SEG_ITEMS = 39;

   typedef struct packed {
      logic        op;
      logic [7:0]  opcode;
      logic [31:0] nsid;
      logic [63:0] prp1;
      logic [31:0] dw10;
      logic [31:0] dw11;
      logic [31:0] dw12;
      logic [31:0] dw3;
   } host_cmd_type;

   typedef struct packed {
      host_cmd_type             cmd;
      logic                     typed;
      nvmeqp_pkg::rsp_beat_type beat;
   } stim_row_type;

   localparam stim_row_type DIR_ROWS [14] = '{
      '{'{nvmeqp_pkg::OP_COMPLETION, 8'h00, 32'h0, 64'h0, 32'h0, 32'h0, 32'h0, 32'h0000_0000},
        1'b1, '{nvmeqp_pkg::KIND_EMPTY, 64'hC, 32'h0, 16'h0, 11'h0, 1'b1}},
      '{'{nvmeqp_pkg::OP_COMPLETION, 8'h00, 32'h0, 64'h0, 32'h0, 32'h0, 32'h0, 32'hFFFE_FFFF},
        1'b1, '{nvmeqp_pkg::KIND_EMPTY, 64'hC, 32'h0, 16'h0, 11'h0, 1'b1}},
      '{'{nvmeqp_pkg::OP_COMPLETION, 8'h00, 32'h0, 64'h0, 32'h0, 32'h0, 32'h0, 32'h0001_1234},
        1'b1, '{nvmeqp_pkg::KIND_DOORBELL, 64'h1004, 32'd1, 16'h1234, 11'h0, 1'b1}},
      '{'{nvmeqp_pkg::OP_COMPLETION, 8'h00, 32'h0, 64'h0, 32'h0, 32'h0, 32'h0, 32'hFFFF_0000},
        1'b0, '0},
      '{'{nvmeqp_pkg::OP_SUBMIT, 8'h00, 32'h0, 64'h0, 32'h0, 32'h0, 32'h0, 32'h0}, 1'b0, '0},
      '{'{nvmeqp_pkg::OP_SUBMIT, 8'hFF, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF,
          32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, 1'b0, '0},
      '{'{nvmeqp_pkg::OP_SUBMIT, 8'h02, 32'h1, 64'h0123_4567_89AB_CDEF, 32'hDEAD_BEEF, 32'h1,
          32'hFF, 32'h0}, 1'b0, '0},
      '{'{nvmeqp_pkg::OP_COMPLETION, 8'h00, 32'h0, 64'h0, 32'h0, 32'h0, 32'h0, 32'h0005_0003},
        1'b0, '0},
      '{'{nvmeqp_pkg::OP_COMPLETION, 8'h00, 32'h0, 64'h0, 32'h0, 32'h0, 32'h0, 32'h0005_0003},
        1'b0, '0},
      '{'{nvmeqp_pkg::OP_COMPLETION, 8'h00, 32'h0, 64'h0, 32'h0, 32'h0, 32'h0, 32'h0000_0003},
        1'b1, '{nvmeqp_pkg::KIND_EMPTY, 64'h4C, 32'h0, 16'h0, 11'h0, 1'b1}},
      '{'{nvmeqp_pkg::OP_COMPLETION, 8'h00, 32'h0, 64'h0, 32'h0, 32'h0, 32'h0, 32'h0001_FFFF},
        1'b1, '{nvmeqp_pkg::KIND_DOORBELL, 64'h1004, 32'd5, 16'hFFFF, 11'h0, 1'b1}},
      '{'{nvmeqp_pkg::OP_SUBMIT, 8'h01, 32'h5A5A_5A5A, 64'h8000_0000_0000_1000, 32'h0,
          32'hFFFF_FFFF, 32'h7, 32'h0}, 1'b0, '0},
      '{'{nvmeqp_pkg::OP_COMPLETION, 8'h00, 32'h0, 64'h0, 32'h0, 32'h0, 32'h0, 32'h0AAB_0004},
        1'b0, '0},
      '{'{nvmeqp_pkg::OP_COMPLETION, 8'h00, 32'h0, 64'h0, 32'h0, 32'h0, 32'h0, 32'hAAAB_5554},
        1'b1, '{nvmeqp_pkg::KIND_DOORBELL, 64'h1004, 32'd7, 16'h5554, 11'h0, 1'b1}}
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;

   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_op = 1'b0;
   logic [7:0]  req_cmd_opcode = '0;
   logic [31:0] req_namespace_id = '0;
   logic [63:0] req_buffer_addr = '0;
   logic [31:0] req_cmd_dword10 = '0;
   logic [31:0] req_cmd_dword11 = '0;
   logic [31:0] req_cmd_dword12 = '0;
   logic [31:0] req_completion_dword3 = '0;

   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_kind;
   logic [63:0] rsp_address;
   logic [31:0] rsp_write_data;
   logic [15:0] rsp_command_id;
   logic [10:0] rsp_status_code;
   logic        rsp_last;

   logic                               csr_we = 1'b0;
   logic [nvmeqp_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [63:0]                        csr_wdata = '0;

   nvmeqp_pkg::cfg_type      cfg = '0;
   logic [5:0]               sub_tail = '0;
   logic [5:0]               cpl_head = '0;
   logic                     cpl_phase = 1'b1;
   logic [15:0]              new_cid = 16'd1;
   logic [15:0]              open_cid = 16'd0;
   nvmeqp_pkg::rsp_beat_type due_beats [$];
   int                       mismatches = 0;
   int                       send_idle_pct = 0;
   int                       rcv_idle_pct = 0;

   nvme_queue_pair_engine dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #5_000_000;
      $display("FAIL");
      $finish;
   end

   function automatic logic [63:0] doorbell_addr(input logic is_cq);
      return cfg.controller_base + nvmeqp_pkg::DB_OFFSET
         + {47'd0, cfg.queue_id, is_cq} * (64'd4 << cfg.stride_log);
   endfunction

   task automatic compute_beats(input host_cmd_type c);
      nvmeqp_pkg::rsp_beat_type b;
      logic [63:0]  entry;
      logic [31:0]  dw;
      logic [15:0]  cid;
      if (c.op == nvmeqp_pkg::OP_SUBMIT) begin
         entry = cfg.sq_base + {52'd0, sub_tail, 6'd0};
         for (int i = 0; i < nvmeqp_pkg::SQE_DWORDS; i++) begin
            case (4'(i))
               nvmeqp_pkg::DW_CDW0: begin
                  dw = {new_cid, 8'd0, c.opcode};
               end
               nvmeqp_pkg::DW_NSID:  dw = c.nsid;
               nvmeqp_pkg::DW_PRP_L: dw = c.prp1[31:0];
               nvmeqp_pkg::DW_PRP_H: dw = c.prp1[63:32];
               nvmeqp_pkg::DW_CDW10: dw = c.dw10;
               nvmeqp_pkg::DW_CDW11: dw = c.dw11;
               nvmeqp_pkg::DW_CDW12: dw = c.dw12;
               default:              dw = '0;
            endcase
            b = '{nvmeqp_pkg::KIND_ENTRY, entry + 64'(4 * i), dw, new_cid, 11'd0, 1'b0};
            due_beats.push_back(b);
         end
         sub_tail = sub_tail + 6'd1;
         b = '{nvmeqp_pkg::KIND_DOORBELL, doorbell_addr(1'b0), {26'd0, sub_tail}, new_cid,
               11'd0, 1'b1};
         due_beats.push_back(b);
         open_cid = new_cid;
         new_cid = new_cid + 16'd1;
      end else begin
         cid = c.dw3[15:0];
         if (c.dw3[16] != cpl_phase) begin
            b = '{nvmeqp_pkg::KIND_EMPTY,
                  cfg.cq_base + {54'd0, cpl_head, 4'd0} + 64'(nvmeqp_pkg::CQE_DW3_OFS),
                  32'd0, 16'd0, 11'd0, 1'b1};
            due_beats.push_back(b);
         end else begin
            cpl_head = cpl_head + 6'd1;
            if (cpl_head == 6'd0) begin
               cpl_phase = ~cpl_phase;
            end
            b = '{nvmeqp_pkg::KIND_DOORBELL, doorbell_addr(1'b1), {26'd0, cpl_head}, cid,
                  11'd0, cid != open_cid};
            due_beats.push_back(b);
            if (cid == open_cid) begin
               b = '{nvmeqp_pkg::KIND_DONE, 64'd0, 32'd0, cid, c.dw3[27:17], 1'b1};
               due_beats.push_back(b);
            end
         end
      end
   endtask

   task automatic offer(input host_cmd_type c);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_op <= c.op;
      req_cmd_opcode <= c.opcode;
      req_namespace_id <= c.nsid;
      req_buffer_addr <= c.prp1;
      req_cmd_dword10 <= c.dw10;
      req_cmd_dword11 <= c.dw11;
      req_cmd_dword12 <= c.dw12;
      req_completion_dword3 <= c.dw3;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      compute_beats(c);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (due_beats.size() != 0) @(posedge clock);
   endtask

   task automatic program_regs(input nvmeqp_pkg::cfg_type c);
      csr_we <= 1'b1;
      csr_index <= nvmeqp_pkg::CSR_CTRL_BASE;
      csr_wdata <= c.controller_base;
      @(posedge clock);
      csr_index <= nvmeqp_pkg::CSR_DB_STRIDE;
      csr_wdata <= 64'(c.stride_log);
      @(posedge clock);
      csr_index <= nvmeqp_pkg::CSR_QUEUE_ID;
      csr_wdata <= 64'(c.queue_id);
      @(posedge clock);
      csr_index <= nvmeqp_pkg::CSR_SQ_BASE;
      csr_wdata <= c.sq_base;
      @(posedge clock);
      csr_index <= nvmeqp_pkg::CSR_CQ_BASE;
      csr_wdata <= c.cq_base;
      @(posedge clock);
      csr_we <= 1'b0;
      cfg = c;
   endtask

   always @(posedge clock) begin : beat_check
      nvmeqp_pkg::rsp_beat_type got;
      nvmeqp_pkg::rsp_beat_type want;
      rsp_ready <= $urandom_range(99) >= rcv_idle_pct;
      if (rsp_valid && rsp_ready) begin
         got = '{nvmeqp_pkg::kind_type'(rsp_kind), rsp_address, rsp_write_data,
                 rsp_command_id, rsp_status_code, rsp_last};
         if (due_beats.size() == 0) begin
            if (mismatches < 10) begin
               $display("unexpected beat: kind %0d addr %h data %h cid %h status %h last %b",
                        got.kind, got.address, got.write_data, got.command_id,
                        got.status_code, got.last);
            end
            mismatches++;
         end else begin
            want = due_beats.pop_front();
            if (got !== want) begin
               if (mismatches < 10) begin
                  $display("beat mismatch: want kind %0d addr %h data %h cid %h",
                           want.kind, want.address, want.write_data, want.command_id,
                           " status %h last %b", want.status_code, want.last);
                  $display("               got  kind %0d addr %h data %h cid %h",
                           got.kind, got.address, got.write_data, got.command_id,
                           " status %h last %b", got.status_code, got.last);
               end
               mismatches++;
            end
         end
      end
   end

   initial begin : stimulus
      host_cmd_type        c;
      nvmeqp_pkg::cfg_type setting;
      int                  pick;
      send_idle_pct = 19;
      rcv_idle_pct = 86;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed table at reset register values
      foreach (DIR_ROWS[k]) begin
         offer(DIR_ROWS[k].cmd);
         if (DIR_ROWS[k].typed) begin
            due_beats[due_beats.size() - 1] = DIR_ROWS[k].beat;
         end
      end

      for (int seg = 0; seg < 3; seg++) begin
         drain();
         case (seg)
            0: begin
               setting = '1;
               send_idle_pct = 19;
               rcv_idle_pct = 86;
            end
            1: begin
               setting.controller_base = {$urandom, $urandom};
               setting.stride_log = 4'($urandom);
               setting.queue_id = 16'($urandom);
               setting.sq_base = {$urandom, $urandom};
               setting.cq_base = {$urandom, $urandom};
               send_idle_pct = 86;
               rcv_idle_pct = 19;
            end
            default: begin
               setting = '0;
               send_idle_pct = 0;
               rcv_idle_pct = 0;
            end
         endcase
         program_regs(setting);

         repeat (SEG_ITEMS) begin
            pick = $urandom_range(99);
            c = '0;
            if (pick < 48) begin
               c.op = nvmeqp_pkg::OP_SUBMIT;
               c.opcode = 8'($urandom);
               c.nsid = $urandom;
               c.prp1 = {$urandom, $urandom};
               c.dw10 = $urandom;
               c.dw11 = $urandom;
               c.dw12 = $urandom;
            end else begin
               // mostly well-formed completions of the outstanding command
               c.op = nvmeqp_pkg::OP_COMPLETION;
               c.dw3 = $urandom;
               c.dw3[16] = (pick < 53) ? ~cpl_phase : cpl_phase;
               if (pick >= 60) begin
                  c.dw3[15:0] = open_cid;
               end
            end
            offer(c);
         end
      end

      drain();
      repeat (20) @(posedge clock);
      if (mismatches == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/core/nvmeqp_pkg.sv
rtl/core/nvmeqp_beat_gen.sv
rtl/core/nvme_queue_pair_engine.sv
dv/tb_nvme_queue_pair_engine.sv
